// File: hw/rtl/ssd_pkg.sv
package ssd_pkg;

  // Field widths of the configuration registers.
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 11;
  localparam int DISP_BITS      = 6;
  localparam int RADIUS_BITS    = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  localparam int PIX_BITS   = 8;
  localparam int DEPTH_BITS = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_DISP   = 63;

  localparam int HEIGHT_LIMIT = 1024;

  // Register values after reset.
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int RST_DISP   = 15;
  localparam int RST_RADIUS = 1;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_DISPARITY = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RADIUS = 2'd3;

  typedef struct packed {
    logic [PIX_BITS-1:0] right_pixel;
    logic [PIX_BITS-1:0] left_pixel;
    logic                flush;
  } ssd_in_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic                  last_of_frame;
  } ssd_out_t;

  // One pixel pair as written to the line stores.
  typedef struct packed {
    logic [PIX_BITS-1:0] right;
    logic [PIX_BITS-1:0] left;
  } ssd_pix_t;

endpackage

// File: hw/rtl/stereo_sad_disparity.sv
// An item that completes a window starts a search of the (2r+1)^2 window for
//   each disparity 0..d, one line store read per window element, and then a
//   division that scales the best disparity; no new item is taken until the
//   result is in the output register. An item that yields no result is taken
//   without a stall while no search is pending.
// Reset: synchronous, active low; clears control state and loads the default
//   registers. The line stores are not cleared.
module stereo_sad_disparity #(
  parameter int MAX_WIDTH  = ssd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = ssd_pkg::DEF_MAX_RADIUS,
  parameter int MAX_DISP   = ssd_pkg::DEF_MAX_DISP
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ssd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ssd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ssd_pkg::ssd_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ssd_pkg::ssd_out_t                   out_data
);

  localparam int AW = $clog2(2*MAX_RADIUS*MAX_WIDTH + 2*MAX_RADIUS + MAX_DISP + 1);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = ssd_pkg::HEIGHT_BITS;
  localparam int DB = $clog2(MAX_DISP + 1);
  localparam int RB = $clog2(MAX_RADIUS + 1);
  localparam int PB = WB + HB;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_PUT   = 2'd3;

  // Configuration registers, as written.
  logic [ssd_pkg::WIDTH_BITS-1:0]  width_r;
  logic [ssd_pkg::HEIGHT_BITS-1:0] height_r;
  logic [ssd_pkg::DISP_BITS-1:0]   disp_r;
  logic [ssd_pkg::RADIUS_BITS-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ssd_pkg::WIDTH_BITS'(ssd_pkg::RST_WIDTH);
      height_r <= ssd_pkg::HEIGHT_BITS'(ssd_pkg::RST_HEIGHT);
      disp_r   <= ssd_pkg::DISP_BITS'(ssd_pkg::RST_DISP);
      radius_r <= ssd_pkg::RADIUS_BITS'(ssd_pkg::RST_RADIUS);
    end else if (cfg_we) begin
      case (cfg_index)
        ssd_pkg::REG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata[ssd_pkg::WIDTH_BITS-1:0];
        end
        ssd_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata[ssd_pkg::HEIGHT_BITS-1:0];
        end
        ssd_pkg::REG_MAX_DISPARITY: begin
          disp_r <= cfg_wdata[ssd_pkg::DISP_BITS-1:0];
        end
        ssd_pkg::REG_WINDOW_RADIUS: begin
          radius_r <= cfg_wdata[ssd_pkg::RADIUS_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register values are clamped into the range the hardware supports.
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [DB-1:0] d_eff;
  logic [RB-1:0] r_eff;
  logic [PB-1:0] total;
  logic [PB:0]   lag;

  assign w_eff = (width_r == '0) ? WB'(1) :
                 (width_r > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(width_r);
  assign h_eff = (height_r == '0) ? HB'(1) :
                 (height_r > ssd_pkg::HEIGHT_LIMIT) ? HB'(ssd_pkg::HEIGHT_LIMIT) :
                 height_r;
  assign d_eff = (disp_r == '0) ? DB'(1) :
                 (disp_r > MAX_DISP) ? DB'(MAX_DISP) : DB'(disp_r);
  assign r_eff = (radius_r > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(radius_r);

  assign total = PB'(w_eff) * PB'(h_eff);

  // The window of pixel p is complete once the input reaches p + lag: r rows
  // and r columns below and right of it, plus the largest disparity.
  assign lag = (PB+1)'(r_eff) * (PB+1)'(w_eff) + (PB+1)'(r_eff) + (PB+1)'(d_eff);

  // Frame positions. The input position counts every item of the frame,
  // flush items included; the output position is the next pixel to answer,
  // kept also as row and column so that no division is needed.
  logic [PB:0]   in_pos_r, in_pos_nxt;
  logic [PB-1:0] out_pos_r, out_pos_nxt;
  logic [HB-1:0] out_row_r, out_row_nxt;
  logic [WB-1:0] out_col_r, out_col_nxt;
  logic [1:0]    state_r, state_nxt;
  logic          last_pend_r;
  logic          out_valid_r, out_valid_nxt;
  ssd_pkg::ssd_out_t out_data_r;

  logic in_acc, store_en, emit, last, load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign store_en = in_pos_r < {1'b0, total};
  assign emit     = in_pos_r >= lag;
  assign last     = out_pos_r >= (total - PB'(1));

  always_comb begin
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (in_acc) begin
      if (emit && last) begin
        // End of frame: the next item starts a new one.
        in_pos_nxt  = '0;
        out_pos_nxt = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else begin
        in_pos_nxt = in_pos_r + (PB+1)'(1);
        if (emit) begin
          out_pos_nxt = out_pos_r + PB'(1);
          if (WB'(out_col_r + WB'(1)) == w_eff) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + HB'(1);
          end else begin
            out_col_nxt = out_col_r + WB'(1);
          end
        end
      end
    end
  end

  // Window search and scaling units.
  ssd_pkg::ssd_pix_t wr_pix;
  logic              eng_done;
  logic [DB-1:0]     best_k;
  logic              div_done;
  logic [ssd_pkg::DEPTH_BITS-1:0] quo;

  // Flush items and pixels past the frame write nothing useful; a flush
  // inside the frame stores zeros.
  assign wr_pix = in_data.flush ? '0 : {in_data.right_pixel, in_data.left_pixel};

  ssd_match #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_DISP   (MAX_DISP)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc && store_en),
    .wr_addr  (AW'(in_pos_r)),
    .wr_pix   (wr_pix),
    .start    (in_acc && emit),
    .job_addr (AW'(out_pos_r)),
    .job_row  (out_row_r),
    .job_col  (out_col_r),
    .job_w    (w_eff),
    .job_h    (h_eff),
    .job_d    (d_eff),
    .job_r    (r_eff),
    .done     (eng_done),
    .best_k   (best_k)
  );

  ssd_div #(
    .MAX_DISP (MAX_DISP)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (eng_done),
    .k_in  (best_k),
    .d_in  (d_eff),
    .done  (div_done),
    .quo   (quo)
  );

  // Sequencer: search, scale, then hand the result to the output register.
  // The output register parts the result side from the input side, so the
  // next item may be taken while a result waits there.
  assign load = (state_r == ST_PUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && emit) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (eng_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      last_pend_r <= last;
    end
    if (load) begin
      out_data_r.depth         <= quo;
      out_data_r.last_of_frame <= last_pend_r;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_pos_r    <= in_pos_nxt;
      out_pos_r   <= out_pos_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The search unit finishes only while the sequencer waits for it.
  a_eng_done: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> (state_r == ST_MATCH))
    else $error("window search finished outside the search state");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the scaling state");

  // An item that completes a window starts a search at once.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> (state_r == ST_MATCH))
    else $error("search not started for a complete window");

  // The last pixel of a frame rewinds both positions.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && last) |=> ((in_pos_r == '0) && (out_pos_r == '0)))
    else $error("frame positions not rewound after the last pixel");

  // A finished result reaches the output register when it is free.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUT && !out_stall) |=> out_valid_r)
    else $error("finished result not presented");

endmodule

// File: hw/rtl/ssd_div.sv
module ssd_div #(
  parameter int MAX_DISP = ssd_pkg::DEF_MAX_DISP
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [$clog2(MAX_DISP+1)-1:0]   k_in,
  input  logic [$clog2(MAX_DISP+1)-1:0]   d_in,
  output logic                            done,
  output logic [ssd_pkg::DEPTH_BITS-1:0]  quo
);

  localparam int DB   = $clog2(MAX_DISP + 1);
  localparam int NUMB = DB + 8;
  localparam int CNTB = $clog2(NUMB + 1);

  logic [NUMB-1:0] num_r, num_nxt;
  logic [DB-1:0]   rem_r, rem_nxt;
  logic [DB-1:0]   d_r, d_nxt;
  logic [CNTB-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DB:0]     rem_sh;
  logic            ge;

  // Restoring division, one quotient bit per cycle; the quotient shifts
  // into the numerator register as the numerator shifts out.
  assign rem_sh = {rem_r, num_r[NUMB-1]};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = (NUMB'(k_in) << 8) - NUMB'(k_in);
      rem_nxt  = '0;
      d_nxt    = d_in;
      cnt_nxt  = CNTB'(NUMB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DB'(rem_sh - {1'b0, d_r}) : DB'(rem_sh);
      num_nxt = {num_r[NUMB-2:0], ge};
      cnt_nxt = cnt_r - CNTB'(1);
      if (cnt_r == CNTB'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r[ssd_pkg::DEPTH_BITS-1:0];

endmodule

// File: hw/rtl/ssd_match.sv
module ssd_match #(
  parameter int MAX_WIDTH  = ssd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = ssd_pkg::DEF_MAX_RADIUS,
  parameter int MAX_DISP   = ssd_pkg::DEF_MAX_DISP
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Line store write port
  input  logic                          wr_en,
  input  logic [$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+MAX_DISP+1)-1:0] wr_addr,
  input  ssd_pkg::ssd_pix_t             wr_pix,
  // Job
  input  logic                          start,
  input  logic [$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+MAX_DISP+1)-1:0] job_addr,
  input  logic [ssd_pkg::HEIGHT_BITS-1:0] job_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  job_col,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  job_w,
  input  logic [ssd_pkg::HEIGHT_BITS-1:0] job_h,
  input  logic [$clog2(MAX_DISP+1)-1:0]   job_d,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] job_r,
  output logic                          done,
  output logic [$clog2(MAX_DISP+1)-1:0] best_k
);

  localparam int AW = $clog2(2*MAX_RADIUS*MAX_WIDTH + 2*MAX_RADIUS + MAX_DISP + 1);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = ssd_pkg::HEIGHT_BITS;
  localparam int DB = $clog2(MAX_DISP + 1);
  localparam int RB = $clog2(MAX_RADIUS + 1);
  localparam int CB = $clog2(2*MAX_RADIUS + 1);
  localparam int SB = $clog2((2*MAX_RADIUS+1) * (2*MAX_RADIUS+1) * 255 + 1);
  localparam int NB = ((WB > DB) ? WB : DB) + 3;
  localparam int MB = HB + 2;
  localparam int PW = ssd_pkg::PIX_BITS;

  logic [PW-1:0] rmem [2**AW];
  logic [PW-1:0] lmem [2**AW];

  // Job registers
  logic [WB-1:0] w_r, col_r;
  logic [HB-1:0] h_r, row_r;
  logic [DB-1:0] d_r;
  logic [RB-1:0] r_r;
  logic [AW-1:0] rstart_r;

  // Window sequencer
  logic          run_r, run_nxt;
  logic [CB-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [DB-1:0] k_r, k_nxt;
  logic [AW-1:0] rowaddr_r, rowaddr_nxt;

  // Read stage
  logic          s1_v_r, s1_vr_r, s1_vl_r, s1_endk_r, s1_end_r;
  logic [DB-1:0] s1_k_r;
  logic [PW-1:0] rpix_r, lpix_r;

  // Accumulate stage
  logic [SB-1:0] sum_r, sum_nxt, best_r, best_nxt;
  logic [DB-1:0] bestk_r, bestk_nxt;
  logic          done_r, done_nxt;

  logic [AW-1:0]        rw, rstart, raddr, laddr;
  logic [CB-1:0]        two_r;
  logic signed [MB-1:0] m_s;
  logic signed [NB-1:0] n_s, nk_s;
  logic                 m_ok, vr, vl, endk, endall;
  logic [PW-1:0]        ra, la, diff;
  logic [SB-1:0]        acc;

  assign rw     = AW'((WB+RB)'(job_r) * (WB+RB)'(job_w));
  assign rstart = job_addr - rw - AW'(job_r);

  assign two_r = CB'(r_r) << 1;
  assign raddr = rowaddr_r + AW'(b_r);
  assign laddr = raddr + AW'(k_r);

  assign m_s  = $signed(MB'(row_r)) - $signed(MB'(r_r)) + $signed(MB'(a_r));
  assign n_s  = $signed(NB'(col_r)) - $signed(NB'(r_r)) + $signed(NB'(b_r));
  assign nk_s = n_s + $signed(NB'(k_r));
  assign m_ok = (m_s >= 0) && (m_s < $signed(MB'(h_r)));
  assign vr   = m_ok && (n_s >= 0) && (n_s < $signed(NB'(w_r)));
  assign vl   = m_ok && (nk_s >= 0) && (nk_s < $signed(NB'(w_r)));

  assign endk   = (a_r == two_r) && (b_r == two_r);
  assign endall = endk && (k_r == d_r);

  // Walk the window row by row, once per disparity.
  always_comb begin
    run_nxt     = run_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    k_nxt       = k_r;
    rowaddr_nxt = rowaddr_r;
    if (start) begin
      run_nxt     = 1'b1;
      a_nxt       = '0;
      b_nxt       = '0;
      k_nxt       = '0;
      rowaddr_nxt = rstart;
    end else if (run_r) begin
      if (b_r == two_r) begin
        b_nxt = '0;
        if (a_r == two_r) begin
          a_nxt       = '0;
          rowaddr_nxt = rstart_r;
          if (k_r == d_r) begin
            run_nxt = 1'b0;
          end else begin
            k_nxt = k_r + DB'(1);
          end
        end else begin
          a_nxt       = a_r + CB'(1);
          rowaddr_nxt = rowaddr_r + AW'(w_r);
        end
      end else begin
        b_nxt = b_r + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rmem[wr_addr] <= wr_pix.right;
      lmem[wr_addr] <= wr_pix.left;
    end
    rpix_r <= rmem[raddr];
    lpix_r <= lmem[laddr];
  end

  // Pixels outside the image count as zero.
  assign ra   = s1_vr_r ? rpix_r : '0;
  assign la   = s1_vl_r ? lpix_r : '0;
  assign diff = (ra > la) ? (ra - la) : (la - ra);
  assign acc  = sum_r + SB'(diff);

  always_comb begin
    sum_nxt   = sum_r;
    best_nxt  = best_r;
    bestk_nxt = bestk_r;
    done_nxt  = 1'b0;
    if (start) begin
      sum_nxt  = '0;
      best_nxt = '1;
    end else if (s1_v_r) begin
      if (s1_endk_r) begin
        sum_nxt = '0;
        // Ties go to the larger disparity.
        if (acc <= best_r) begin
          best_nxt  = acc;
          bestk_nxt = s1_k_r;
        end
      end else begin
        sum_nxt = acc;
      end
      done_nxt = s1_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w_r      <= job_w;
      h_r      <= job_h;
      d_r      <= job_d;
      r_r      <= job_r;
      row_r    <= job_row;
      col_r    <= job_col;
      rstart_r <= rstart;
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    rowaddr_r <= rowaddr_nxt;
    s1_vr_r   <= vr;
    s1_vl_r   <= vl;
    s1_endk_r <= endk;
    s1_end_r  <= endall;
    s1_k_r    <= k_r;
    sum_r     <= sum_nxt;
    best_r    <= best_nxt;
    bestk_r   <= bestk_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      s1_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      s1_v_r <= run_r;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign best_k = bestk_r;

endmodule
